// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the compensation RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BTPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BTPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btpc_pkg.sv =====
// Shared types, widths and constants of the barometric compensation block.
// Used by every module of the block; depends on nothing else.
package btpc_pkg;

  // Port widths.
  localparam int RAW_W       = 24;
  localparam int CAL_W       = 16;
  localparam int ADDR_W      = 5;
  localparam int APB_DATA_W  = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int TEMP_OUT_W  = 15;
  localparam int PRES_OUT_W  = 18;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 40;

  // Fixed division shifts of the compensation formulas.
  localparam int SH_TEMP = 23;
  localparam int SH_OFF  = 7;
  localparam int SH_SENS = 8;
  localparam int SH_T2   = 31;
  localparam int SH_PROD = 21;
  localparam int SH_PRES = 15;

  // Internal datapath widths.
  localparam int DT_W    = RAW_W + 1;
  localparam int PT_W    = DT_W + CAL_W + 1;
  localparam int PD_W    = 2 * DT_W;
  localparam int QT_W    = PT_W - SH_TEMP;
  localparam int OFF_W   = 36;
  localparam int T2_W    = PD_W - 1 - SH_T2;
  localparam int TEMP_W  = QT_W + 1;
  localparam int SQ1_W   = 2 * QT_W;
  localparam int SQ2_W   = 2 * TEMP_W;
  localparam int CORR_W  = SQ2_W + 4;
  localparam int TT_W    = TEMP_W + 1;
  localparam int FIN_W   = CORR_W + 2;
  localparam int SPLIT_W = 23;
  localparam int PLO_W   = RAW_W + SPLIT_W;
  localparam int PHI_W   = RAW_W + 1 + FIN_W - SPLIT_W;
  localparam int PROD_W  = PHI_W + SPLIT_W;
  localparam int Q1_W    = PROD_W - SH_PROD;
  localparam int X_W     = Q1_W + 1;
  localparam int PRES_W  = X_W - SH_PRES;

  // Formula constants.
  localparam int T_REF       = 2000;
  localparam int T_LOW_OFS   = 3500;   // 20.00 C down to -15.00 C
  localparam int K_OFF2      = 5;
  localparam int K_OFF2_LOW  = 7;
  localparam int K_SENS2_LOW = 11;
  localparam int TEMP_MIN    = -10000;
  localparam int TEMP_MAX    = 15000;
  localparam int PRES_MAX    = 200000;

  localparam logic [RAW_W-1:0] RAW_MAX   = {RAW_W{1'b1}};
  localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(1);

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RAW_BAD = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_SENS  = 3'd0,
    REG_OFF   = 3'd1,
    REG_TCS   = 3'd2,
    REG_TCO   = 3'd3,
    REG_TREF  = 3'd4,
    REG_TSENS = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] off;
    logic [CAL_W-1:0] tcs;
    logic [CAL_W-1:0] tco;
    logic [CAL_W-1:0] tref;
    logic [CAL_W-1:0] tsens;
  } cal_t;

  // One classified sample pair waiting for the arithmetic pipeline.
  typedef struct packed {
    logic                   raw_bad;
    logic [RAW_W-1:0]       d1;
    logic signed [DT_W-1:0] dt;
  } item_t;

endpackage

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Top level of the barometric temperature and pressure compensation block.
// Holds the calibration registers and the APB port; uses btpc_pkg, btpc_front,
// btpc_queue and btpc_back.
//
// The block takes one pair of raw 24-bit conversions per transaction and
// returns one result per pair: temperature in 0.01 C, pressure in Pa and a
// status (ok, raw value 0 or all ones, result out of range; numeric fields
// are zero unless ok). A new pair can be accepted on every clock cycle while
// the input queue is not full. Each pair passes through the input queue and
// the stages of the arithmetic pipeline, where the 24 by 46 bit pressure
// product is formed from two partial products. The pipeline freezes while a
// result waits at the output; the input queue of QUEUE_DEPTH entries keeps
// taking pairs until it fills. The six calibration words sit at byte
// addresses 0 to 20 in steps of 4 and reset to 1; write them only while no
// pair is in flight.
module baro_temp_pressure_compensation #(
  parameter int unsigned QUEUE_DEPTH = btpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]       paddr,
  input  logic [btpc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [btpc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // Raw sample pairs
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pressure_raw [23:0], temperature_raw [47:24]
  input  logic [btpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Compensated results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // temp_centideg [14:0], pres_pascal [32:15], zeros [39:33]
  output logic [btpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // result_status [1:0]
  output logic [btpc_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import btpc_pkg::*;

  cal_t             cal_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic [CAL_W-1:0] rd_val;

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wr_item, q_rd_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '{default: CAL_RESET};
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SENS:  cal_q.sens  <= pwdata[CAL_W-1:0];
        REG_OFF:   cal_q.off   <= pwdata[CAL_W-1:0];
        REG_TCS:   cal_q.tcs   <= pwdata[CAL_W-1:0];
        REG_TCO:   cal_q.tco   <= pwdata[CAL_W-1:0];
        REG_TREF:  cal_q.tref  <= pwdata[CAL_W-1:0];
        REG_TSENS: cal_q.tsens <= pwdata[CAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SENS:  rd_val = cal_q.sens;
      REG_OFF:   rd_val = cal_q.off;
      REG_TCS:   rd_val = cal_q.tcs;
      REG_TCO:   rd_val = cal_q.tco;
      REG_TREF:  rd_val = cal_q.tref;
      REG_TSENS: rd_val = cal_q.tsens;
      default:   rd_val = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

  btpc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .tref_i        (cal_q.tref),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_wr_item)
  );

  btpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_rd_item)
  );

  btpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cal_i         (cal_q),
    .q_empty_i     (q_empty),
    .q_item_i      (q_rd_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/btpc_front.sv =====
// Input side of the compensation block: accepts raw sample pairs, flags
// invalid conversions and forms the temperature difference. Uses btpc_pkg.
module btpc_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pressure_raw [23:0], temperature_raw [47:24]
  input  logic [btpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [btpc_pkg::CAL_W-1:0]       tref_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output btpc_pkg::item_t                  q_item_o
);
  import btpc_pkg::*;

  logic [RAW_W-1:0] d1;
  logic [RAW_W-1:0] d2;

  assign d1 = s_axis_tdata[RAW_W-1:0];
  assign d2 = s_axis_tdata[2*RAW_W-1:RAW_W];

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o.d1      = d1;
    q_item_o.raw_bad = (d1 == '0) || (d1 == RAW_MAX) || (d2 == '0) || (d2 == RAW_MAX);
    // The reference word is scaled by 256 before it is taken from D2.
    q_item_o.dt      = $signed({1'b0, d2}) - $signed({1'b0, tref_i, 8'b0});
  end

endmodule

// ===== rtl/btpc_queue.sv =====
// Short FIFO between the input classifier and the arithmetic pipeline.
// Holds btpc_pkg::item_t entries; depth comes from the top level.
`include "assert_macros.svh"

module btpc_queue #(
  parameter int unsigned DEPTH = btpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  btpc_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output btpc_pkg::item_t item_o
);
  import btpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `BTPC_ASSERT_IMPL(a_no_pop_empty, pop_i, cnt_q != '0, "pop from an empty queue")
  `BTPC_ASSERT_IMPL(a_no_push_full, push_i, cnt_q != CNT_W'(DEPTH), "push into a full queue")
  `BTPC_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

// ===== rtl/btpc_back.sv =====
// Arithmetic pipeline of the compensation block: first- and second-order
// terms, split wide product, range check and output register. Uses btpc_pkg.
`include "assert_macros.svh"

module btpc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  btpc_pkg::cal_t                   cal_i,
  input  logic                             q_empty_i,
  input  btpc_pkg::item_t                  q_item_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // temp_centideg [14:0], pres_pascal [32:15], zeros [39:33]
  output logic [btpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // result_status [1:0]
  output logic [btpc_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import btpc_pkg::*;

  localparam int NST = 12;

  logic           adv;
  logic           stall;
  logic           res_ok;
  logic [NST-1:0] vld_q;

  // Stage 1: item taken from the queue.
  logic                   s1_bad_q;
  logic [RAW_W-1:0]       s1_d1_q;
  logic signed [DT_W-1:0] s1_dt_q;
  // Stage 2: first-order products.
  logic                   s2_bad_q;
  logic [RAW_W-1:0]       s2_d1_q;
  logic signed [PT_W-1:0] s2_pt_q, s2_po_q, s2_ps_q, s2_pt_d, s2_po_d, s2_ps_d;
  logic signed [PD_W-1:0] s2_pd_q, s2_pd_d;
  // Stage 3: first-order temperature, offset and sensitivity.
  logic                    s3_bad_q;
  logic [RAW_W-1:0]        s3_d1_q;
  logic signed [QT_W-1:0]  s3_qt_q, s3_qt_d;
  logic signed [OFF_W-1:0] s3_off1_q, s3_off1_d, s3_sens1_q, s3_sens1_d;
  logic [T2_W-1:0]         s3_t2_q;
  logic [PT_W-1:0]         pt_b, po_b, ps_b;
  // Stage 4: squares for the second-order terms.
  logic                     s4_bad_q, s4_low_q, s4_low_d, s4_vlow_q, s4_vlow_d;
  logic [RAW_W-1:0]         s4_d1_q;
  logic [SQ1_W-1:0]         s4_sq1_q, s4_sq1_d;
  logic [SQ2_W-1:0]         s4_sq2_q, s4_sq2_d;
  logic signed [TEMP_W-1:0] s4_temp1_q, s4_temp1_d, diff2;
  logic signed [OFF_W-1:0]  s4_off1_q, s4_sens1_q;
  logic [T2_W-1:0]          s4_t2_q;
  // Stage 5: second-order corrections.
  logic                    s5_bad_q;
  logic [RAW_W-1:0]        s5_d1_q;
  logic [CORR_W-1:0]       s5_off2_q, s5_off2_d, s5_sens2_q, s5_sens2_d;
  logic [CORR_W-1:0]       c5, c7, c11;
  logic signed [TT_W-1:0]  s5_temp2_q, s5_temp2_d;
  logic signed [OFF_W-1:0] s5_off1_q, s5_sens1_q;
  // Stage 6: corrected offset and sensitivity.
  logic                    s6_bad_q;
  logic [RAW_W-1:0]        s6_d1_q;
  logic signed [TT_W-1:0]  s6_temp2_q;
  logic signed [FIN_W-1:0] s6_offf_q, s6_offf_d, s6_sensf_q, s6_sensf_d;
  // Stage 7: partial products of D1 times sensitivity.
  logic                    s7_bad_q;
  logic signed [TT_W-1:0]  s7_temp2_q;
  logic signed [FIN_W-1:0] s7_offf_q;
  logic [PLO_W-1:0]        s7_plo_q, s7_plo_d;
  logic signed [PHI_W-1:0] s7_phi_q, s7_phi_d;
  // Stage 8: full product.
  logic                     s8_bad_q;
  logic signed [TT_W-1:0]   s8_temp2_q;
  logic signed [FIN_W-1:0]  s8_offf_q;
  logic signed [PROD_W-1:0] s8_prod_q, s8_prod_d;
  // Stage 9: product scaled down.
  logic                    s9_bad_q;
  logic signed [TT_W-1:0]  s9_temp2_q;
  logic signed [FIN_W-1:0] s9_offf_q;
  logic signed [Q1_W-1:0]  s9_q1_q, s9_q1_d;
  logic [PROD_W-1:0]       prod_b;
  // Stage 10: offset removed.
  logic                   s10_bad_q;
  logic signed [TT_W-1:0] s10_temp2_q;
  logic signed [X_W-1:0]  s10_x_q, s10_x_d;
  // Stage 11: pressure.
  logic                     s11_bad_q;
  logic signed [TT_W-1:0]   s11_temp2_q;
  logic signed [PRES_W-1:0] s11_pres_q, s11_pres_d;
  logic [X_W-1:0]           x_b;
  // Stage 12: output register.
  logic [TEMP_OUT_W-1:0] out_temp_q, out_temp_d;
  logic [PRES_OUT_W-1:0] out_pres_q, out_pres_d;
  status_e               out_status_q, out_status_d;

  // The whole pipeline moves together unless a result waits at the output.
  assign adv     = !vld_q[NST-1] || m_axis_tready;
  assign q_pop_o = adv && !q_empty_i;

  assign stall  = m_axis_tvalid && !m_axis_tready;
  assign res_ok = m_axis_tvalid && (out_status_q == ST_OK);

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = {{(OUT_TDATA_W - TEMP_OUT_W - PRES_OUT_W){1'b0}}, out_pres_q, out_temp_q};
  assign m_axis_tuser  = out_status_q;

  always_comb begin
    s2_pt_d = PT_W'(s1_dt_q) * PT_W'($signed({1'b0, cal_i.tsens}));
    s2_po_d = PT_W'(s1_dt_q) * PT_W'($signed({1'b0, cal_i.tco}));
    s2_ps_d = PT_W'(s1_dt_q) * PT_W'($signed({1'b0, cal_i.tcs}));
    s2_pd_d = PD_W'(s1_dt_q) * PD_W'(s1_dt_q);

    // Signed divisions round toward zero: bias negative values before shifting.
    pt_b = s2_pt_q + PT_W'({SH_TEMP{s2_pt_q[PT_W-1]}});
    po_b = s2_po_q + PT_W'({SH_OFF{s2_po_q[PT_W-1]}});
    ps_b = s2_ps_q + PT_W'({SH_SENS{s2_ps_q[PT_W-1]}});
    s3_qt_d    = $signed(pt_b[PT_W-1:SH_TEMP]);
    s3_off1_d  = $signed({{(OFF_W - CAL_W - 16){1'b0}}, cal_i.off, 16'b0})
               + OFF_W'($signed(po_b[PT_W-1:SH_OFF]));
    s3_sens1_d = $signed({{(OFF_W - CAL_W - 15){1'b0}}, cal_i.sens, 15'b0})
               + OFF_W'($signed(ps_b[PT_W-1:SH_SENS]));

    // The quotient is the distance from 20.00 C; diff2 is the distance from -15.00 C.
    diff2      = TEMP_W'(s3_qt_q) + TEMP_W'(T_LOW_OFS);
    s4_temp1_d = TEMP_W'(s3_qt_q) + TEMP_W'(T_REF);
    s4_low_d   = s3_qt_q[QT_W-1];
    s4_vlow_d  = diff2[TEMP_W-1];
    s4_sq1_d   = SQ1_W'(s3_qt_q) * SQ1_W'(s3_qt_q);
    s4_sq2_d   = SQ2_W'(diff2) * SQ2_W'(diff2);

    c5  = CORR_W'(s4_sq1_q) * CORR_W'(K_OFF2);
    c7  = CORR_W'(s4_sq2_q) * CORR_W'(K_OFF2_LOW);
    c11 = CORR_W'(s4_sq2_q) * CORR_W'(K_SENS2_LOW);
    s5_off2_d  = '0;
    s5_sens2_d = '0;
    s5_temp2_d = TT_W'(s4_temp1_q);
    if (s4_low_q) begin
      s5_off2_d  = (c5 >> 1) + (s4_vlow_q ? c7 : '0);
      s5_sens2_d = (c5 >> 2) + (s4_vlow_q ? (c11 >> 1) : '0);
      s5_temp2_d = TT_W'(s4_temp1_q) - TT_W'($signed({1'b0, s4_t2_q}));
    end

    s6_offf_d  = FIN_W'(s5_off1_q) - FIN_W'($signed({1'b0, s5_off2_q}));
    s6_sensf_d = FIN_W'(s5_sens1_q) - FIN_W'($signed({1'b0, s5_sens2_q}));

    s7_plo_d = PLO_W'(s6_d1_q) * PLO_W'(s6_sensf_q[SPLIT_W-1:0]);
    s7_phi_d = PHI_W'($signed({1'b0, s6_d1_q})) * PHI_W'($signed(s6_sensf_q[FIN_W-1:SPLIT_W]));

    s8_prod_d = (PROD_W'(s7_phi_q) <<< SPLIT_W) + PROD_W'($signed({1'b0, s7_plo_q}));

    prod_b  = s8_prod_q + PROD_W'({SH_PROD{s8_prod_q[PROD_W-1]}});
    s9_q1_d = $signed(prod_b[PROD_W-1:SH_PROD]);

    s10_x_d = X_W'(s9_q1_q) - X_W'(s9_offf_q);

    x_b        = s10_x_q + X_W'({SH_PRES{s10_x_q[X_W-1]}});
    s11_pres_d = $signed(x_b[X_W-1:SH_PRES]);

    out_temp_d   = '0;
    out_pres_d   = '0;
    out_status_d = ST_OK;
    if (s11_bad_q) begin
      out_status_d = ST_RAW_BAD;
    end else if ((s11_temp2_q < TT_W'(TEMP_MIN)) || (s11_temp2_q > TT_W'(TEMP_MAX)) ||
                 s11_pres_q[PRES_W-1] || (s11_pres_q == '0) ||
                 (s11_pres_q > PRES_W'(PRES_MAX))) begin
      out_status_d = ST_RANGE;
    end else begin
      out_temp_d = s11_temp2_q[TEMP_OUT_W-1:0];
      out_pres_d = s11_pres_q[PRES_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], q_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_bad_q <= q_item_i.raw_bad;
      s1_d1_q  <= q_item_i.d1;
      s1_dt_q  <= q_item_i.dt;

      s2_bad_q <= s1_bad_q;
      s2_d1_q  <= s1_d1_q;
      s2_pt_q  <= s2_pt_d;
      s2_po_q  <= s2_po_d;
      s2_ps_q  <= s2_ps_d;
      s2_pd_q  <= s2_pd_d;

      s3_bad_q   <= s2_bad_q;
      s3_d1_q    <= s2_d1_q;
      s3_qt_q    <= s3_qt_d;
      s3_off1_q  <= s3_off1_d;
      s3_sens1_q <= s3_sens1_d;
      s3_t2_q    <= s2_pd_q[PD_W-2:SH_T2];

      s4_bad_q   <= s3_bad_q;
      s4_d1_q    <= s3_d1_q;
      s4_low_q   <= s4_low_d;
      s4_vlow_q  <= s4_vlow_d;
      s4_sq1_q   <= s4_sq1_d;
      s4_sq2_q   <= s4_sq2_d;
      s4_temp1_q <= s4_temp1_d;
      s4_off1_q  <= s3_off1_q;
      s4_sens1_q <= s3_sens1_q;
      s4_t2_q    <= s3_t2_q;

      s5_bad_q   <= s4_bad_q;
      s5_d1_q    <= s4_d1_q;
      s5_off2_q  <= s5_off2_d;
      s5_sens2_q <= s5_sens2_d;
      s5_temp2_q <= s5_temp2_d;
      s5_off1_q  <= s4_off1_q;
      s5_sens1_q <= s4_sens1_q;

      s6_bad_q   <= s5_bad_q;
      s6_d1_q    <= s5_d1_q;
      s6_temp2_q <= s5_temp2_q;
      s6_offf_q  <= s6_offf_d;
      s6_sensf_q <= s6_sensf_d;

      s7_bad_q   <= s6_bad_q;
      s7_temp2_q <= s6_temp2_q;
      s7_offf_q  <= s6_offf_q;
      s7_plo_q   <= s7_plo_d;
      s7_phi_q   <= s7_phi_d;

      s8_bad_q   <= s7_bad_q;
      s8_temp2_q <= s7_temp2_q;
      s8_offf_q  <= s7_offf_q;
      s8_prod_q  <= s8_prod_d;

      s9_bad_q   <= s8_bad_q;
      s9_temp2_q <= s8_temp2_q;
      s9_offf_q  <= s8_offf_q;
      s9_q1_q    <= s9_q1_d;

      s10_bad_q   <= s9_bad_q;
      s10_temp2_q <= s9_temp2_q;
      s10_x_q     <= s10_x_d;

      s11_bad_q   <= s10_bad_q;
      s11_temp2_q <= s10_temp2_q;
      s11_pres_q  <= s11_pres_d;

      out_temp_q   <= out_temp_d;
      out_pres_q   <= out_pres_d;
      out_status_q <= out_status_d;
    end
  end

  `BTPC_ASSERT_NEXT(a_pop_enters, q_pop_o, vld_q[0], "popped item did not enter the pipeline")
  `BTPC_ASSERT_IMPL(a_ok_has_pres, res_ok, out_pres_q != '0, "valid result with zero pressure")
  `BTPC_ASSERT_NEXT(a_stall_hold, stall, $stable(m_axis_tdata), "tdata moved in stall")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for baro_temp_pressure_compensation.
// Streams raw conversion pairs under random idling on both sides, predicts each
// compensated result from the programmed calibration, and checks it; uses btpc_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import btpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned EXTREME_PAIRS = 50;
  localparam int unsigned PHASE_PAIRS  = 260;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int          NUM_CAL      = 6;

  // Register slots past the last calibration word; writes there are dropped.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam longint DIV_TEMP  = longint'(1) << 23;
  localparam longint DIV_OFF   = longint'(1) << 7;
  localparam longint DIV_SENS  = longint'(1) << 8;
  localparam longint DIV_T2    = longint'(1) << 31;
  localparam longint DIV_PROD  = longint'(1) << 21;
  localparam longint DIV_PRES  = longint'(1) << 15;

  localparam logic [RAW_W-1:0] D1_NOMINAL = 24'd9085466;
  localparam logic [RAW_W-1:0] D2_NOMINAL = 24'd8569150;

  localparam cal_t TYPICAL_CAL = '{sens: 16'd40127, off: 16'd36924, tcs: 16'd23317,
                                   tco: 16'd23282, tref: 16'd33464, tsens: 16'd28312};

  typedef struct {
    logic signed [TEMP_OUT_W-1:0] temp;
    logic [PRES_OUT_W-1:0]        pres;
    status_e                      status;
  } comp_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // pressure_raw [23:0], temperature_raw [47:24]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // temp_centideg [14:0], pres_pascal [32:15]
  logic [STATUS_W-1:0]     m_axis_tuser;        // result_status [1:0]

  logic [CAL_W-1:0] cal_word [NUM_CAL];
  comp_result_t     pending_results [$];
  int unsigned      err_cnt = 0;
  bit               src_steady = 1'b0;
  bit               snk_steady = 1'b0;

  baro_temp_pressure_compensation i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Compensated temperature and pressure for one raw pair under the current
  // calibration. Divisions are on signed 64-bit values and truncate toward zero.
  function automatic comp_result_t compensate(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
    comp_result_t r;
    longint dt, temp, off, sens, pres, diff, t2, off2, sens2;
    r.temp = '0;
    r.pres = '0;
    r.status = ST_OK;
    if (d1 == '0 || d1 == RAW_MAX || d2 == '0 || d2 == RAW_MAX) begin
      r.status = ST_RAW_BAD;
      return r;
    end
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    dt = longint'(d2) - longint'(cal_word[REG_TREF]) * 256;
    temp = 2000 + (dt * longint'(cal_word[REG_TSENS])) / DIV_TEMP;
    off = longint'(cal_word[REG_OFF]) * 65536 + (longint'(cal_word[REG_TCO]) * dt) / DIV_OFF;
    sens = longint'(cal_word[REG_SENS]) * 32768
           + (longint'(cal_word[REG_TCS]) * dt) / DIV_SENS;
    if (temp < 2000) begin
      diff = temp - 2000;
      t2 = (dt * dt) / DIV_T2;
      off2 = (5 * diff * diff) / 2;
      sens2 = (5 * diff * diff) / 4;
      if (temp < -1500) begin
        diff = temp + 1500;
        off2 += 7 * diff * diff;
        sens2 += (11 * diff * diff) / 2;
      end
    end
    temp -= t2;
    off -= off2;
    sens -= sens2;
    pres = ((longint'(d1) * sens) / DIV_PROD - off) / DIV_PRES;
    if (temp < -10000 || temp > 15000 || pres <= 0 || pres > 200000) begin
      r.status = ST_RANGE;
    end else begin
      r.temp = temp[TEMP_OUT_W-1:0];
      r.pres = pres[PRES_OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CAL_W-1:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return CAL_W'($urandom_range(1, 65534));
    endcase
  endfunction

  function automatic cal_t rand_cal();
    cal_t c;
    c.sens = rand_word();
    c.off = rand_word();
    c.tcs = rand_word();
    c.tco = rand_word();
    c.tref = rand_word();
    c.tsens = rand_word();
    return c;
  endfunction

  function automatic cal_t uniform_cal(logic [CAL_W-1:0] w);
    return '{sens: w, off: w, tcs: w, tco: w, tref: w, tsens: w};
  endfunction

  // One APB transfer. psel stays high afterwards so that transfers can follow
  // back to back; apb_release ends a series.
  task automatic apb_access(input logic [2:0] idx, input bit wr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [CAL_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] unused;
    // Upper bits carry junk; only the low word is kept.
    wdata = {16'($urandom()), value};
    apb_access(idx, 1'b1, wdata, unused);
    if (idx < NUM_CAL) cal_word[idx] = value;
  endtask

  task automatic check_readback();
    logic [APB_DATA_W-1:0] rdata;
    for (int i = 0; i < NUM_CAL; i++) begin
      apb_access(3'(i), 1'b0, '0, rdata);
      if (rdata[CAL_W-1:0] !== cal_word[i]) begin
        $error("prdata: expected %h, got %h (register %0d)", cal_word[i], rdata[CAL_W-1:0], i);
        err_cnt++;
      end
    end
    apb_release();
  endtask

  // Only called while no pair is in flight.
  task automatic program_calibration(input cal_t c);
    apb_write(REG_SENS, c.sens);
    apb_write(REG_OFF, c.off);
    apb_write(REG_TCS, c.tcs);
    apb_write(REG_TCO, c.tco);
    apb_write(REG_TREF, c.tref);
    apb_write(REG_TSENS, c.tsens);
    apb_write(REG_SPARE_LO, rand_word());
    apb_write(REG_SPARE_HI, rand_word());
    check_readback();
  endtask

  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int unsigned gap;
    gap = draw_gap(src_steady);
    if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {d2, d1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(compensate(d1, d2));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly temperatures near the reference point so that the correction bands
  // and valid pressures are reached; the rest is unrestricted or flagged raw data.
  task automatic gen_pair(output logic [RAW_W-1:0] d1, output logic [RAW_W-1:0] d2);
    int unsigned kind;
    longint      center;
    int          spread;
    kind = $urandom_range(0, 15);
    d1 = RAW_W'($urandom_range(0, 24'hFFFFFF));
    d2 = RAW_W'($urandom_range(0, 24'hFFFFFF));
    if (kind == 2) begin
      case ($urandom_range(0, 3))
        0: d1 = '0;
        1: d1 = RAW_MAX;
        2: d2 = '0;
        default: d2 = RAW_MAX;
      endcase
    end else if (kind > 2) begin
      spread = (kind < 10) ? 1_500_000 : 6_000_000;
      center = longint'(cal_word[REG_TREF]) * 256
               + longint'($urandom_range(0, 2 * spread)) - spread;
      if (center < 1) center = 1;
      if (center > longint'(RAW_MAX) - 1) center = longint'(RAW_MAX) - 1;
      d2 = center[RAW_W-1:0];
      d1 = RAW_W'($urandom_range(4_000_000, 16_777_214));
    end
  endtask

  task automatic test_reset_calibration();
    check_readback();
    send_pair(24'd1, 24'd1);
    send_pair(RAW_MAX - 1, RAW_MAX - 1);
    send_pair(D1_NOMINAL, D2_NOMINAL);
    drain();
  endtask

  task automatic test_invalid_raw();
    program_calibration(TYPICAL_CAL);
    send_pair('0, D2_NOMINAL);
    send_pair(RAW_MAX, D2_NOMINAL);
    send_pair(D1_NOMINAL, '0);
    send_pair(D1_NOMINAL, RAW_MAX);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    drain();
  endtask

  // Sweeps the temperature from far below the extra low band to above the range,
  // then drives the pressure past both ends of its range.
  task automatic test_temperature_bands();
    logic [RAW_W-1:0] d2_sweep [8];
    d2_sweep = '{24'd1, 24'd4000000, 24'd6500000, 24'd7400000, 24'd7800000,
                 24'd8566784, 24'd9500000, RAW_MAX - 1};
    program_calibration(TYPICAL_CAL);
    foreach (d2_sweep[i]) send_pair(D1_NOMINAL, d2_sweep[i]);
    send_pair(24'd1, D2_NOMINAL);
    send_pair(RAW_MAX - 1, D2_NOMINAL);
    drain();
  endtask

  task automatic test_calibration_extremes();
    cal_t             settings [4];
    logic [RAW_W-1:0] d1, d2;
    settings[0] = uniform_cal('0);
    settings[1] = uniform_cal('1);
    settings[2] = uniform_cal(16'd1);
    settings[3] = uniform_cal(16'd65534);
    foreach (settings[i]) begin
      program_calibration(settings[i]);
      repeat (EXTREME_PAIRS) begin
        gen_pair(d1, d2);
        send_pair(d1, d2);
      end
      drain();
    end
  endtask

  task automatic test_random_stream();
    logic [RAW_W-1:0] d1, d2;
    repeat (NUM_PHASES) begin
      program_calibration(rand_cal());
      repeat (PHASE_PAIRS) begin
        gen_pair(d1, d2);
        send_pair(d1, d2);
      end
      drain();
    end
  endtask

  initial begin : result_check
    comp_result_t                 exp_r;
    int unsigned                  gap;
    logic signed [TEMP_OUT_W-1:0] got_temp;
    logic [PRES_OUT_W-1:0]        got_pres;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap(snk_steady);
      if ($urandom_range(0, 63) == 0) snk_steady = !snk_steady;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_temp = m_axis_tdata[TEMP_OUT_W-1:0];
      got_pres = m_axis_tdata[TEMP_OUT_W +: PRES_OUT_W];
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: tdata %h, tuser %0d", m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_temp !== exp_r.temp) begin
          $error("temp_centideg: expected %0d, got %0d", exp_r.temp, got_temp);
          err_cnt++;
        end
        if (got_pres !== exp_r.pres) begin
          $error("pres_pascal: expected %0d, got %0d", exp_r.pres, got_pres);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $error("result_status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:TEMP_OUT_W+PRES_OUT_W] !== '0) begin
          $error("tdata padding: expected 0, got %h",
                 m_axis_tdata[OUT_TDATA_W-1:TEMP_OUT_W+PRES_OUT_W]);
          err_cnt++;
        end
      end
    end
  end

  initial begin : run
    foreach (cal_word[i]) cal_word[i] = CAL_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_calibration();
    test_invalid_raw();
    test_temperature_bands();
    test_calibration_extremes();
    test_random_stream();
    // Any stray result after the last expected one shows up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== baro_temp_pressure_compensation.f =====
+incdir+rtl
rtl/btpc_pkg.sv
rtl/btpc_front.sv
rtl/btpc_queue.sv
rtl/btpc_back.sv
rtl/baro_temp_pressure_compensation.sv
test/tb_top.sv
